### design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, codes and control types of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int NUM_PAGES  = 4096;
   localparam int PAGE_BYTES = 4096;
   localparam int ADDR_W     = $clog2(NUM_PAGES);
   localparam int PTR_W      = ADDR_W + 1;
   localparam int SIZE_W     = 25;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int CNT_W      = SIZE_W - PAGE_SHIFT + 1;
   localparam int END_W      = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_RESERVE = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_MARK,
      ST_RESP
   } step_type;

   typedef enum logic [2:0] {
      ACT_CLEAR,
      ACT_IDLE,
      ACT_SCAN,
      ACT_SETUP,
      ACT_MARK,
      ACT_RESP
   } act_type;

   typedef enum logic [2:0] {
      C_CLR_DONE,
      C_ACCEPT,
      C_SCAN_DONE,
      C_NOT_FOUND,
      C_MARK_DONE,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
      logic     hold;
      logic     dispatch;
   } ctrl_type;

   typedef struct packed {
      logic     clr_done;
      logic     accept;
      logic     scan_done;
      logic     not_found;
      logic     mark_done;
      logic     out_free;
      mode_type mode;
   } status_type;

endpackage

### design/bitmap_page_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// first-fit contiguous page allocator over a one-bit-per-page free map
// ----------------------------------------------------------------------------
// after reset a clearing pass marks every page used; no request is taken
// during it
// allocate: scan at one map bit per cycle, then, if a run fits, mark it used
// page by page, then load the result register
// free / reserve: mark the clipped range page by page, then load the result
// register; one request at a time; the page map memory port sets the rate
module bitmap_page_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // page_number [11:0], byte_size [36:12], zero fill above
   input  logic [bpa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode [1:0]
   input  logic [bpa_pkg::MODE_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // page_number_out [11:0], zero fill above
   output logic [bpa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // ok [0]
   output logic                              rsp_tuser
);

   bpa_pkg::ctrl_type              ctrl;
   bpa_pkg::status_type            status;
   bpa_pkg::step_type              step;
   logic [bpa_pkg::ADDR_W-1:0]     rsp_page;

   bpa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .step   (step)
   );

   bpa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_page   (req_tdata[bpa_pkg::ADDR_W-1:0]),
      .req_size   (req_tdata[bpa_pkg::ADDR_W+bpa_pkg::SIZE_W-1:bpa_pkg::ADDR_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_ok     (rsp_tuser),
      .rsp_page   (rsp_page),
      .status     (status)
   );

   assign rsp_tdata = bpa_pkg::RSP_DATA_W'(rsp_page);

   // a failed or range request carries no page
   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("failed result carries a nonzero page");

   // one request in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in work");

   // clearing pass runs before any request
   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!req_tready && step == bpa_pkg::ST_CLEAR))
      else $error("request path open before the map is cleared");

endmodule

### design/bpa_ucode_rom.sv
// ----------------------------------------------------------------------------
// bpa_ucode_rom
// control store: one control word per sequencer step
// ----------------------------------------------------------------------------
module bpa_ucode_rom (
   input  bpa_pkg::step_type step,
   output bpa_pkg::ctrl_type ctrl
);

   always_comb begin
      case (step)
         bpa_pkg::ST_CLEAR: begin
            ctrl = '{bpa_pkg::ACT_CLEAR, bpa_pkg::C_CLR_DONE, bpa_pkg::ST_IDLE, 1'b1, 1'b0};
         end
         bpa_pkg::ST_IDLE: begin
            ctrl = '{bpa_pkg::ACT_IDLE, bpa_pkg::C_ACCEPT, bpa_pkg::ST_IDLE, 1'b1, 1'b1};
         end
         bpa_pkg::ST_SCAN: begin
            ctrl = '{bpa_pkg::ACT_SCAN, bpa_pkg::C_SCAN_DONE, bpa_pkg::ST_CHECK, 1'b1, 1'b0};
         end
         bpa_pkg::ST_CHECK: begin
            ctrl = '{bpa_pkg::ACT_SETUP, bpa_pkg::C_NOT_FOUND, bpa_pkg::ST_RESP, 1'b0, 1'b0};
         end
         bpa_pkg::ST_MARK: begin
            ctrl = '{bpa_pkg::ACT_MARK, bpa_pkg::C_MARK_DONE, bpa_pkg::ST_RESP, 1'b1, 1'b0};
         end
         bpa_pkg::ST_RESP: begin
            ctrl = '{bpa_pkg::ACT_RESP, bpa_pkg::C_OUT_FREE, bpa_pkg::ST_IDLE, 1'b1, 1'b0};
         end
         default: begin
            ctrl = '{bpa_pkg::ACT_IDLE, bpa_pkg::C_ACCEPT, bpa_pkg::ST_IDLE, 1'b1, 1'b1};
         end
      endcase
   end

endmodule

### design/bpa_seq.sv
// ----------------------------------------------------------------------------
// bpa_seq
// step counter with conditional jumps and mode dispatch over the control store
// ----------------------------------------------------------------------------
module bpa_seq (
   input  logic                clock,
   input  logic                reset,
   input  bpa_pkg::status_type status,
   output bpa_pkg::ctrl_type   ctrl,
   output bpa_pkg::step_type   step
);

   bpa_pkg::step_type step_ff;
   bpa_pkg::step_type step_in;
   bpa_pkg::step_type dispatch_step;
   logic              cond_hit;

   bpa_ucode_rom u_rom (
      .step (step_ff),
      .ctrl (ctrl)
   );

   always_comb begin
      case (ctrl.cond)
         bpa_pkg::C_CLR_DONE:  cond_hit = status.clr_done;
         bpa_pkg::C_ACCEPT:    cond_hit = status.accept;
         bpa_pkg::C_SCAN_DONE: cond_hit = status.scan_done;
         bpa_pkg::C_NOT_FOUND: cond_hit = status.not_found;
         bpa_pkg::C_MARK_DONE: cond_hit = status.mark_done;
         bpa_pkg::C_OUT_FREE:  cond_hit = status.out_free;
         default:              cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      case (status.mode)
         bpa_pkg::MODE_ALLOC:   dispatch_step = bpa_pkg::ST_SCAN;
         bpa_pkg::MODE_FREE,
         bpa_pkg::MODE_RESERVE: dispatch_step = bpa_pkg::ST_MARK;
         default:               dispatch_step = bpa_pkg::ST_RESP;
      endcase
   end

   always_comb begin
      if (cond_hit) begin
         step_in = ctrl.dispatch ? dispatch_step : ctrl.target;
      end else if (ctrl.hold) begin
         step_in = step_ff;
      end else begin
         step_in = bpa_pkg::step_type'(step_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= bpa_pkg::ST_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

### design/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// page map memory, scan and mark pointers, run counter and result register
// ----------------------------------------------------------------------------
module bpa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bpa_pkg::ctrl_type             ctrl,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bpa_pkg::MODE_W-1:0]    req_mode,
   input  logic [bpa_pkg::ADDR_W-1:0]    req_page,
   input  logic [bpa_pkg::SIZE_W-1:0]    req_size,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_ok,
   output logic [bpa_pkg::ADDR_W-1:0]    rsp_page,
   output bpa_pkg::status_type           status
);

   logic                            mem [bpa_pkg::NUM_PAGES];
   logic                            rd_ff;

   bpa_pkg::mode_type               mode_ff, mode_in;
   logic [bpa_pkg::PTR_W-1:0]       ptr_ff, ptr_in;
   logic [bpa_pkg::PTR_W-1:0]       end_ff, end_in;
   logic [bpa_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [bpa_pkg::CNT_W-1:0]       run_ff, run_in;
   logic [bpa_pkg::ADDR_W-1:0]      head_ff, head_in;
   logic [bpa_pkg::ADDR_W-1:0]      pa_ff, pa_in;
   logic                            pv_ff, pv_in;
   logic                            found_ff, found_in;
   logic                            bit_ff, bit_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            ok_ff, ok_in;
   logic [bpa_pkg::ADDR_W-1:0]      page_out_ff, page_out_in;

   logic                            accept;
   logic                            wr_en;
   logic                            wr_bit;
   logic [bpa_pkg::SIZE_W:0]        size_sum;
   logic [bpa_pkg::CNT_W-1:0]       size_pages;
   logic [bpa_pkg::END_W-1:0]       req_end_raw;
   logic [bpa_pkg::PTR_W-1:0]       req_end;
   logic [bpa_pkg::END_W-1:0]       run_end;
   logic [bpa_pkg::CNT_W-1:0]       run_inc;
   logic                            ptr_at_end;
   logic                            found_now;
   logic                            mark_done;
   logic                            out_free;

   assign req_tready = (ctrl.act == bpa_pkg::ACT_IDLE);
   assign accept     = req_tvalid && req_tready;

   // page count rounded up
   assign size_sum   = {1'b0, req_size} + (bpa_pkg::SIZE_W+1)'(bpa_pkg::PAGE_BYTES - 1);
   assign size_pages = size_sum[bpa_pkg::SIZE_W:bpa_pkg::PAGE_SHIFT];

   assign req_end_raw = bpa_pkg::END_W'(req_page) + bpa_pkg::END_W'(size_pages);
   assign req_end     = (req_end_raw > bpa_pkg::END_W'(bpa_pkg::NUM_PAGES))
                        ? bpa_pkg::PTR_W'(bpa_pkg::NUM_PAGES)
                        : req_end_raw[bpa_pkg::PTR_W-1:0];
   assign run_end     = bpa_pkg::END_W'(head_ff) + bpa_pkg::END_W'(cnt_ff);

   assign run_inc    = run_ff + bpa_pkg::CNT_W'(1);
   assign ptr_at_end = (ptr_ff == bpa_pkg::PTR_W'(bpa_pkg::NUM_PAGES));
   assign found_now  = pv_ff && rd_ff && (run_inc >= cnt_ff);
   assign mark_done  = (ptr_ff >= end_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign status.clr_done  = (ptr_ff == bpa_pkg::PTR_W'(bpa_pkg::NUM_PAGES - 1));
   assign status.accept    = accept;
   assign status.scan_done = found_now || (ptr_at_end && !pv_ff);
   assign status.not_found = !found_ff;
   assign status.mark_done = mark_done;
   assign status.out_free  = out_free;
   assign status.mode      = bpa_pkg::mode_type'(req_mode);

   always_comb begin
      mode_in      = mode_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      cnt_in       = cnt_ff;
      run_in       = run_ff;
      head_in      = head_ff;
      pa_in        = pa_ff;
      pv_in        = 1'b0;
      found_in     = found_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ok_in        = ok_ff;
      page_out_in  = page_out_ff;
      wr_en        = 1'b0;
      wr_bit       = 1'b0;
      case (ctrl.act)
         bpa_pkg::ACT_CLEAR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + bpa_pkg::PTR_W'(1);
         end
         bpa_pkg::ACT_IDLE: begin
            if (accept) begin
               mode_in  = bpa_pkg::mode_type'(req_mode);
               cnt_in   = size_pages;
               ptr_in   = (req_mode == bpa_pkg::MODE_ALLOC) ? '0 : {1'b0, req_page};
               end_in   = req_end;
               bit_in   = (req_mode == bpa_pkg::MODE_FREE);
               run_in   = '0;
               found_in = 1'b0;
            end
         end
         bpa_pkg::ACT_SCAN: begin
            pv_in = !ptr_at_end;
            pa_in = ptr_ff[bpa_pkg::ADDR_W-1:0];
            if (!ptr_at_end) begin
               ptr_in = ptr_ff + bpa_pkg::PTR_W'(1);
            end
            if (pv_ff) begin
               if (rd_ff) begin
                  run_in = run_inc;
                  if (run_ff == '0) begin
                     head_in = pa_ff;
                  end
               end else begin
                  run_in = '0;
               end
            end
            if (found_now) begin
               found_in = 1'b1;
            end
         end
         bpa_pkg::ACT_SETUP: begin
            ptr_in = {1'b0, head_ff};
            end_in = run_end[bpa_pkg::PTR_W-1:0];
            bit_in = 1'b0;
         end
         bpa_pkg::ACT_MARK: begin
            if (!mark_done) begin
               wr_en  = 1'b1;
               wr_bit = bit_ff;
               ptr_in = ptr_ff + bpa_pkg::PTR_W'(1);
            end
         end
         bpa_pkg::ACT_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (mode_ff == bpa_pkg::MODE_ALLOC) begin
                  ok_in       = found_ff;
                  page_out_in = found_ff ? head_ff : '0;
               end else begin
                  ok_in       = (mode_ff != bpa_pkg::MODE_NONE);
                  page_out_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      end_ff      <= end_in;
      cnt_ff      <= cnt_in;
      run_ff      <= run_in;
      head_ff     <= head_in;
      pa_ff       <= pa_in;
      found_ff    <= found_in;
      bit_ff      <= bit_in;
      ok_ff       <= ok_in;
      page_out_ff <= page_out_in;
   end

   // page map, one bit per page, 1 means free
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff[bpa_pkg::ADDR_W-1:0]] <= wr_bit;
      end
      rd_ff <= mem[ptr_ff[bpa_pkg::ADDR_W-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_ok     = ok_ff;
   assign rsp_page   = page_out_ff;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// directed and random traffic into the bitmap page allocator; an in-order
// page map model predicts the ok flag and first page of every response
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic                       ok;
      logic [bpa_pkg::ADDR_W-1:0] page;
   } page_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bpa_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [bpa_pkg::MODE_W-1:0]     req_tuser = bpa_pkg::MODE_NONE;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [bpa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;

   bit              page_free [bpa_pkg::NUM_PAGES];
   page_result_type expected_results [$];
   int              fail_count = 0;

   bitmap_page_allocator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic void mark_pages(input longint first, input longint count,
                                      input bit value);
      for (longint p = first; p < first + count && p < bpa_pkg::NUM_PAGES; p++) begin
         page_free[p] = value;
      end
   endfunction

   function automatic page_result_type predict_page_result(
         input bpa_pkg::mode_type m,
         input logic [bpa_pkg::ADDR_W-1:0] pg,
         input logic [bpa_pkg::SIZE_W-1:0] sz);
      page_result_type res;
      longint          pages;
      longint          run;
      int              head;
      bit              found;
      res   = '0;
      pages = (longint'(sz) + bpa_pkg::PAGE_BYTES - 1) / bpa_pkg::PAGE_BYTES;
      run   = 0;
      head  = 0;
      found = 1'b0;
      case (m)
         bpa_pkg::MODE_ALLOC: begin
            // first fit, lowest page first
            for (int p = 0; p < bpa_pkg::NUM_PAGES && !found; p++) begin
               if (!page_free[p]) begin
                  run = 0;
               end else begin
                  if (run == 0) head = p;
                  run++;
                  if (run >= pages) found = 1'b1;
               end
            end
            if (found) begin
               mark_pages(head, pages, 1'b0);
               res.ok   = 1'b1;
               res.page = head[bpa_pkg::ADDR_W-1:0];
            end
         end
         bpa_pkg::MODE_FREE: begin
            mark_pages(pg, pages, 1'b1);
            res.ok = 1'b1;
         end
         bpa_pkg::MODE_RESERVE: begin
            mark_pages(pg, pages, 1'b0);
            res.ok = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic send_request(input bpa_pkg::mode_type m,
                               input logic [bpa_pkg::ADDR_W-1:0] pg,
                               input logic [bpa_pkg::SIZE_W-1:0] sz);
      int gap;
      gap = gap_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {{(bpa_pkg::REQ_DATA_W - bpa_pkg::SIZE_W - bpa_pkg::ADDR_W){1'b0}},
                     sz, pg};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_page_result(m, pg, sz));
   endtask

   // response backpressure
   initial begin
      int run_len;
      int stall;
      forever begin
         if ($urandom_range(0, 9) == 0) run_len = $urandom_range(100, 300);
         else run_len = $urandom_range(1, 12);
         repeat (run_len) @(posedge clock);
         stall = gap_cycles();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      page_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response ok=%0d page_number_out=%0d",
                   rsp_tuser, rsp_tdata[bpa_pkg::ADDR_W-1:0]);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.ok) begin
               $error("ok expected %0d actual %0d", want.ok, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[bpa_pkg::ADDR_W-1:0] !== want.page) begin
               $error("page_number_out expected %0d actual %0d",
                      want.page, rsp_tdata[bpa_pkg::ADDR_W-1:0]);
               fail_count++;
            end
         end
      end
   end

   task automatic test_empty_map();
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd0);
      send_request(bpa_pkg::MODE_ALLOC, 12'd9, 25'd4096);
      send_request(bpa_pkg::MODE_FREE, 12'd7, 25'd0);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd0);
      send_request(bpa_pkg::MODE_RESERVE, 12'd3, 25'd0);
   endtask

   task automatic test_alloc_rounding();
      send_request(bpa_pkg::MODE_FREE, 12'd0, 25'd16777216);
      send_request(bpa_pkg::MODE_ALLOC, 12'hFFF, 25'd0);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd1);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd4096);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd4097);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd8193);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd16777216);
   endtask

   task automatic test_range_clipping();
      send_request(bpa_pkg::MODE_RESERVE, 12'd4095, 25'd8192);
      send_request(bpa_pkg::MODE_FREE, 12'd4094, 25'd12288);
      send_request(bpa_pkg::MODE_RESERVE, 12'd100, 25'd16777216);
      send_request(bpa_pkg::MODE_FREE, 12'd4094, 25'd12288);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd8192);
   endtask

   task automatic test_unused_mode();
      send_request(bpa_pkg::MODE_NONE, 12'd4095, 25'd16777216);
      send_request(bpa_pkg::MODE_NONE, 12'd0, 25'd0);
   endtask

   task automatic test_full_map();
      send_request(bpa_pkg::MODE_RESERVE, 12'd0, 25'd16777216);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd0);
      send_request(bpa_pkg::MODE_FREE, 12'd4095, 25'd1);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd4096);
      send_request(bpa_pkg::MODE_FREE, 12'd0, 25'd16777216);
      send_request(bpa_pkg::MODE_ALLOC, 12'd0, 25'd16777216);
   endtask

   function automatic logic [bpa_pkg::SIZE_W-1:0] random_size();
      int r;
      int pages;
      int trim;
      r = $urandom_range(0, 99);
      if (r < 4) return 25'd16777216;
      if (r < 12) return bpa_pkg::SIZE_W'($urandom_range(0, 16777216));
      if (r < 20) return 25'd0;
      pages = $urandom_range(1, 8);
      if ($urandom_range(0, 1) != 0) return bpa_pkg::SIZE_W'(pages * bpa_pkg::PAGE_BYTES);
      trim = $urandom_range(0, bpa_pkg::PAGE_BYTES - 1);
      return bpa_pkg::SIZE_W'(pages * bpa_pkg::PAGE_BYTES - trim);
   endfunction

   task automatic test_random_traffic();
      int                         r;
      logic [bpa_pkg::ADDR_W-1:0] pg;
      for (int i = 0; i < 110; i++) begin
         if ($urandom_range(0, 24) == 0) begin
            send_request(bpa_pkg::MODE_NONE,
                         bpa_pkg::ADDR_W'($urandom_range(0, bpa_pkg::NUM_PAGES - 1)),
                         random_size());
         end
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) begin
            pg = bpa_pkg::ADDR_W'($urandom_range(bpa_pkg::NUM_PAGES - 8,
                                                 bpa_pkg::NUM_PAGES - 1));
         end else begin
            pg = bpa_pkg::ADDR_W'($urandom_range(0, bpa_pkg::NUM_PAGES - 1));
         end
         if (r < 45) send_request(bpa_pkg::MODE_ALLOC, pg, random_size());
         else if (r < 78) send_request(bpa_pkg::MODE_FREE, pg, random_size());
         else send_request(bpa_pkg::MODE_RESERVE, pg, random_size());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_map();
      test_alloc_rounding();
      test_range_clipping();
      test_unused_mode();
      test_full_map();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("bitmap_page_allocator_core: match");
      end else begin
         $display("bitmap_page_allocator_core: mismatch");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("bitmap_page_allocator_core: mismatch");
      $finish;
   end

endmodule

### files.f
design/bpa_pkg.sv
design/bpa_ucode_rom.sv
design/bpa_seq.sv
design/bpa_dp.sv
design/bitmap_page_allocator_core.sv
dv/tb.sv
